/* sv/lrbs_pkg.sv */
// ============================================================================
// Late reverberation bin suppressor package
// Shared constants, codes and types for the bin suppressor.
// ============================================================================
package lrbs_pkg;

  localparam int NUM_BINS  = 512;
  localparam int HIST_DEPTH = 8;

  localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int SLOT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HADDR_W = BIN_W + SLOT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int GAIN_W     = 17;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_RATIO = 2'd0,
    CFG_SUB_FACTOR  = 2'd1,
    CFG_FLOOR_GAIN  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_META,
    ST_CALC,
    ST_MODEL,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_SCALE,
    ST_FINISH
  } state_e;

  // Per-bin bookkeeping: the history is full once every slot was written,
  // and the slot field points at the next slot to write.
  typedef struct packed {
    logic              full;
    logic [SLOT_W-1:0] slot;
  } meta_t;

endpackage

/* sv/late_reverb_bin_suppressor_unit.sv */
// ============================================================================
// Late reverberation bin suppressor
// Per-bin spectral subtraction of a decaying reverb model built from history.
// ============================================================================
// Usage: one complex spectral bin enters per input beat on the s_axis group
// (bin number, real and imaginary part in tdata, the voice flag in tuser).
// One result beat leaves on the m_axis group for each input beat, in order:
// the scaled bin and the gain in tdata, the history-full flag in tuser.
// Items are processed one at a time. An item whose bin history is full and
// that takes the subtraction path presents its result after these steps:
// the bookkeeping read, a bit-serial square root (which also covers the
// eight history reads and multiply-accumulates), the model and the
// products, a restoring divider, and the scale and register of the result.
// Other items skip the divider. The block returns to idle as the result is
// registered and takes the next input beat from there. The history and the
// per-bin bookkeeping live in synchronous memories with registered read data.
// After reset the bookkeeping memory is cleared, one bin per cycle, over all
// NUM_BINS (512) bins; s_axis_tready stays low during that pass, while
// configuration writes are taken at any time. The finished result sits in
// an output register, so the next item is accepted and computed while a
// stalled receiver holds the previous beat; only the final write-back waits
// until that register frees up.
// ============================================================================
module late_reverb_bin_suppressor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [lrbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lrbs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [47:0]                     s_axis_tdata,  // bin_index, in_re, in_im, pad
  input  logic                            s_axis_tuser,  // voice_active
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [55:0]                     m_axis_tdata,  // out_re, out_im, applied_gain, pad
  output logic                            m_axis_tuser   // history_full
);

  localparam int CALC_CYC = (lrbs_pkg::HIST_DEPTH + 1 > 16) ? lrbs_pkg::HIST_DEPTH + 1 : 16;
  localparam int CNT_W    = $clog2(CALC_CYC + 1);
  localparam int MEMD     = 1 << lrbs_pkg::HADDR_W;

  // Configuration registers.
  logic [15:0] decay_q, subf_q;
  logic [16:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= 16'd13231;
      subf_q  <= 16'd58982;
      floor_q <= 17'd6554;
    end else if (cfg_we_i) begin
      unique case (lrbs_pkg::cfg_idx_e'(cfg_idx_i))
        lrbs_pkg::CFG_DECAY_RATIO: decay_q <= cfg_data_i[15:0];
        lrbs_pkg::CFG_SUB_FACTOR:  subf_q  <= cfg_data_i[15:0];
        lrbs_pkg::CFG_FLOOR_GAIN:  floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memories.
  lrbs_pkg::meta_t meta_mem [lrbs_pkg::NUM_BINS];
  logic [15:0]     hist_mem [MEMD];

  lrbs_pkg::meta_t                meta_rd_q;
  logic [15:0]                    hist_rd_q;
  logic                           meta_we;
  logic [lrbs_pkg::BIN_W-1:0]     meta_waddr;
  lrbs_pkg::meta_t                meta_wdata;
  logic                           hist_we;
  logic [lrbs_pkg::HADDR_W-1:0]   hist_raddr, hist_waddr;

  // Control and datapath registers.
  lrbs_pkg::state_e state_q, state_d;
  logic                         clr_q;
  logic [lrbs_pkg::BIN_W-1:0]   clr_addr_q;
  logic [lrbs_pkg::BIN_W-1:0]   bin_q;
  logic signed [15:0]           re_q, im_q;
  logic                         voice_q, full_q, sup_q;
  logic [lrbs_pkg::SLOT_W-1:0]  slot_q, rptr_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [31:0]                  rad_q;
  logic [19:0]                  rem_q;
  logic [15:0]                  root_q;
  logic [15:0]                  w_q;
  logic [34:0]                  acc_q;
  logic [15:0]                  model_q;
  logic [31:0]                  p1_q, den_q, drem_q;
  logic [15:0]                  dlow_q, quo_q;
  logic [16:0]                  gain_q;
  logic signed [34:0]           pre_re_q, pre_im_q;
  logic                         out_valid_q;
  logic [55:0]                  out_data_q;
  logic                         out_full_q;

  logic accept, out_free;
  logic signed [15:0] sat_re, sat_im;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Memory ports.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = bin_q;
    meta_wdata = '0;
    if (clr_q) begin
      meta_we    = 1'b1;
      meta_waddr = clr_addr_q;
    end else if (state_q == lrbs_pkg::ST_FINISH && out_free) begin
      meta_we         = 1'b1;
      meta_wdata.full = full_q ||
                        (slot_q == lrbs_pkg::SLOT_W'(lrbs_pkg::HIST_DEPTH - 1));
      meta_wdata.slot = (slot_q == lrbs_pkg::SLOT_W'(lrbs_pkg::HIST_DEPTH - 1)) ?
                        '0 : slot_q + 1'b1;
    end
    hist_we    = (state_q == lrbs_pkg::ST_FINISH) && out_free;
    hist_waddr = {bin_q, slot_q};
    hist_raddr = {bin_q, rptr_q};
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_rd_q <= meta_mem[s_axis_tdata[lrbs_pkg::BIN_W-1:0]];
    if (hist_we) hist_mem[hist_waddr] <= root_q;
    hist_rd_q <= hist_mem[hist_raddr];
  end

  // Clearing pass over the bookkeeping memory after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == lrbs_pkg::BIN_W'(lrbs_pkg::NUM_BINS - 1)) clr_q <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lrbs_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      lrbs_pkg::ST_IDLE: begin
        s_axis_tready = !clr_q;
        if (accept) state_d = lrbs_pkg::ST_META;
      end
      lrbs_pkg::ST_META:  state_d = lrbs_pkg::ST_CALC;
      lrbs_pkg::ST_CALC:
        if (cnt_q == CNT_W'(CALC_CYC - 1)) state_d = lrbs_pkg::ST_MODEL;
      lrbs_pkg::ST_MODEL: state_d = lrbs_pkg::ST_MUL1;
      lrbs_pkg::ST_MUL1:
        if (full_q && voice_q && (root_q > model_q)) state_d = lrbs_pkg::ST_MUL2;
        else                                         state_d = lrbs_pkg::ST_SCALE;
      lrbs_pkg::ST_MUL2:  state_d = lrbs_pkg::ST_DIV;
      lrbs_pkg::ST_DIV:
        if (cnt_q == CNT_W'(15)) state_d = lrbs_pkg::ST_SCALE;
      lrbs_pkg::ST_SCALE: state_d = lrbs_pkg::ST_FINISH;
      lrbs_pkg::ST_FINISH:
        if (out_free) state_d = lrbs_pkg::ST_IDLE;
      default: state_d = lrbs_pkg::ST_IDLE;
    endcase
  end

  // Datapath.
  logic [19:0] sq_rem_n, sq_trial;
  logic [32:0] div_tmp;
  logic [47:0] num_full;
  logic [35:0] acc_rnd;
  logic [31:0] hw_prod;
  logic signed [33:0] prod_re, prod_im;

  always_comb begin
    sq_rem_n = {rem_q[17:0], rad_q[31:30]};
    sq_trial = {2'b00, root_q, 2'b01};
    div_tmp  = {drem_q, dlow_q[15]};
    num_full = p1_q * model_q;
    acc_rnd  = {1'b0, acc_q} + 36'd32768;
    hw_prod  = hist_rd_q * w_q;
    prod_re  = re_q * $signed({1'b0, gain_q});
    prod_im  = im_q * $signed({1'b0, gain_q});
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lrbs_pkg::ST_IDLE:
        if (accept) begin
          bin_q   <= s_axis_tdata[lrbs_pkg::BIN_W-1:0];
          re_q    <= s_axis_tdata[24:9];
          im_q    <= s_axis_tdata[40:25];
          voice_q <= s_axis_tuser;
        end
      lrbs_pkg::ST_META: begin
        full_q <= meta_rd_q.full;
        slot_q <= meta_rd_q.slot;
        rptr_q <= (meta_rd_q.slot == '0) ?
                  lrbs_pkg::SLOT_W'(lrbs_pkg::HIST_DEPTH - 1) : meta_rd_q.slot - 1'b1;
        cnt_q  <= '0;
        rad_q  <= $unsigned(32'(re_q) * 32'(re_q)) + $unsigned(32'(im_q) * 32'(im_q));
        rem_q  <= '0;
        root_q <= '0;
        acc_q  <= '0;
        w_q    <= decay_q;
      end
      lrbs_pkg::ST_CALC: begin
        cnt_q  <= cnt_q + 1'b1;
        rptr_q <= (rptr_q == '0) ?
                  lrbs_pkg::SLOT_W'(lrbs_pkg::HIST_DEPTH - 1) : rptr_q - 1'b1;
        if (cnt_q < CNT_W'(16)) begin
          rad_q <= {rad_q[29:0], 2'b00};
          if (sq_rem_n >= sq_trial) begin
            rem_q  <= sq_rem_n - sq_trial;
            root_q <= {root_q[14:0], 1'b1};
          end else begin
            rem_q  <= sq_rem_n;
            root_q <= {root_q[14:0], 1'b0};
          end
        end
        if (cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(lrbs_pkg::HIST_DEPTH)) begin
          acc_q <= acc_q + 35'(hw_prod);
          w_q   <= 16'(((w_q * decay_q) + 32'd32768) >> 16);
        end
      end
      lrbs_pkg::ST_MODEL:
        model_q <= (acc_rnd[35:32] != '0) ? 16'hFFFF : acc_rnd[31:16];
      lrbs_pkg::ST_MUL1: begin
        p1_q  <= subf_q * model_q;
        den_q <= root_q * root_q;
        sup_q <= full_q && voice_q && (root_q > model_q);
        if (!full_q)                                    gain_q <= lrbs_pkg::UNITY_GAIN;
        else if (floor_q > lrbs_pkg::UNITY_GAIN)        gain_q <= lrbs_pkg::UNITY_GAIN;
        else                                            gain_q <= floor_q;
      end
      lrbs_pkg::ST_MUL2: begin
        drem_q <= num_full[47:16];
        dlow_q <= num_full[15:0];
        cnt_q  <= '0;
      end
      lrbs_pkg::ST_DIV: begin
        cnt_q  <= cnt_q + 1'b1;
        dlow_q <= {dlow_q[14:0], 1'b0};
        if (div_tmp >= {1'b0, den_q}) begin
          drem_q <= 32'(div_tmp - {1'b0, den_q});
          quo_q  <= {quo_q[14:0], 1'b1};
        end else begin
          drem_q <= div_tmp[31:0];
          quo_q  <= {quo_q[14:0], 1'b0};
        end
        if (cnt_q == CNT_W'(15)) begin
          gain_q <= lrbs_pkg::UNITY_GAIN -
                    {1'b0, quo_q[14:0], (div_tmp >= {1'b0, den_q})};
        end
      end
      lrbs_pkg::ST_SCALE: begin
        pre_re_q <= 35'(prod_re) + 35'sd32768;
        pre_im_q <= 35'(prod_im) + 35'sd32768;
      end
      default: ;
    endcase
  end

  // Rounding shift and saturation of the scaled parts.
  logic signed [18:0] sh_re, sh_im;
  always_comb begin
    sh_re = pre_re_q[34:16];
    sh_im = pre_im_q[34:16];
    if (sh_re > 19'sd32767)       sat_re = 16'sh7FFF;
    else if (sh_re < -19'sd32768) sat_re = -16'sh8000;
    else                          sat_re = sh_re[15:0];
    if (sh_im > 19'sd32767)       sat_im = 16'sh7FFF;
    else if (sh_im < -19'sd32768) sat_im = -16'sh8000;
    else                          sat_im = sh_im[15:0];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == lrbs_pkg::ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lrbs_pkg::ST_FINISH && out_free) begin
      out_data_q <= {7'd0, gain_q, sat_im, sat_re};
      out_full_q <= full_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_full_q;

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_q || state_q != lrbs_pkg::ST_IDLE) |-> !s_axis_tready)
    else $error("input accepted while busy or clearing");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> state_q == lrbs_pkg::ST_IDLE)
    else $error("item in flight during clearing pass");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrbs_pkg::ST_SCALE && sup_q) |-> (gain_q != '0 && gain_q <= lrbs_pkg::UNITY_GAIN))
    else $error("subtraction gain out of range");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrbs_pkg::ST_FINISH && out_free) |=> m_axis_tvalid)
    else $error("finished result not presented");

endmodule

/* tb/testbench.sv */
// ============================================================================
// Bin suppressor testbench
// Streams complex bins through the late reverb suppressor and checks every
// result beat against a behavioral predictor kept alongside the stimulus.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

  // One input beat and one predicted result beat.
  typedef struct {
    logic [8:0]  bin;
    logic [15:0] re;
    logic [15:0] im;
    logic        voice;
  } bin_item_t;

  typedef struct {
    logic [15:0] re;
    logic [15:0] im;
    logic [16:0] gain;
    logic        full;
  } bin_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [16:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  late_reverb_bin_suppressor_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Predictor state: register copies and the per-bin magnitude history.
  logic [15:0] decay_q, subtract_q;
  logic [16:0] floor_q;
  logic [15:0] mag_hist [lrbs_pkg::NUM_BINS*lrbs_pkg::HIST_DEPTH];
  int unsigned hist_fill [lrbs_pkg::NUM_BINS];
  int unsigned next_slot [lrbs_pkg::NUM_BINS];

  bin_item_t   pending_bins[$];
  bin_result_t expected_bins[$];

  int  errors;
  int  n_sent, n_recv, n_full, n_sub;
  longint cycles;
  bit  idle_enable;
  logic in_fire;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] int_sqrt(logic [31:0] x);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Round-to-nearest product with gain, saturated to 16 bit signed.
  function automatic logic [15:0] apply_gain(logic signed [15:0] x, logic [16:0] g);
    longint p;
    p = longint'(x) * longint'(g) + 32768;
    p = p >>> 16;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  // Computes the result for one bin and advances that bin's history.
  function automatic bin_result_t suppress_bin(bin_item_t it);
    bin_result_t r;
    int unsigned b, wp, slot, base;
    logic [31:0] sq;
    longint unsigned mag, acc, w, model, num, den;
    logic [16:0] g;
    b = it.bin % lrbs_pkg::NUM_BINS;
    base = b * lrbs_pkg::HIST_DEPTH;
    wp = next_slot[b] % lrbs_pkg::HIST_DEPTH;
    sq = 32'(longint'($signed(it.re)) * $signed(it.re)
           + longint'($signed(it.im)) * $signed(it.im));
    mag = int_sqrt(sq);
    if (mag > 65535) mag = 65535;
    g = lrbs_pkg::UNITY_GAIN;
    r.full = 1'b0;
    if (hist_fill[b] >= lrbs_pkg::HIST_DEPTH) begin
      r.full = 1'b1;
      acc = 0;
      w = decay_q;
      for (int a = 0; a < lrbs_pkg::HIST_DEPTH; a++) begin
        slot = (wp + lrbs_pkg::HIST_DEPTH - 1 - a) % lrbs_pkg::HIST_DEPTH;
        acc += longint'(mag_hist[base + slot]) * w;
        w = (w * decay_q + 32768) >> 16;
      end
      model = (acc + 32768) >> 16;
      if (model > 65535) model = 65535;
      if (it.voice && mag > model) begin
        num = longint'(subtract_q) * model * model;
        den = mag * mag;
        g = 17'(65536 - num / den);
        n_sub++;
      end else begin
        g = (floor_q > lrbs_pkg::UNITY_GAIN) ? lrbs_pkg::UNITY_GAIN : floor_q;
      end
      n_full++;
    end
    mag_hist[base + wp] = mag[15:0];
    next_slot[b] = (wp + 1) % lrbs_pkg::HIST_DEPTH;
    if (hist_fill[b] < lrbs_pkg::HIST_DEPTH) hist_fill[b]++;
    r.re = apply_gain(it.re, g);
    r.im = apply_gain(it.im, g);
    r.gain = g;
    return r;
  endfunction

  // Appends one bin to the stimulus queue.
  function automatic void queue_bin(bin_item_t it);
    pending_bins = {pending_bins, it};
  endfunction

  // Records whether the input beat was taken at the last rising edge.
  always @(posedge clk_i) begin
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Driver: presents queued bins, with random gaps between beats while idle_enable is set.
  int drv_gap;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      drv_gap <= 0;
    end else if (s_axis_tvalid && !in_fire) begin
      // Hold the current beat until it is taken.
    end else if (drv_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      drv_gap <= drv_gap - 1;
    end else if (pending_bins.size() > 0 && !(idle_enable && $urandom_range(0, 7) == 0)) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {7'd0, pending_bins[0].im, pending_bins[0].re, pending_bins[0].bin};
      s_axis_tuser <= pending_bins[0].voice;
      pending_bins.delete(0);
    end else begin
      s_axis_tvalid <= 1'b0;
      if (idle_enable) drv_gap <= $urandom_range(1, 11) - 1;
    end
  end

  // The prediction is made when a beat is accepted, in input order.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      bin_item_t it;
      it.bin = s_axis_tdata[8:0];
      it.re = s_axis_tdata[24:9];
      it.im = s_axis_tdata[40:25];
      it.voice = s_axis_tuser;
      expected_bins = {expected_bins, suppress_bin(it)};
      n_sent++;
    end
  end

  // Receiver back-pressure in random bursts while idle_enable is set.
  int rcv_gap;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rcv_gap <= 0;
    end else if (rcv_gap > 0) begin
      m_axis_tready <= 1'b0;
      rcv_gap <= rcv_gap - 1;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      rcv_gap <= $urandom_range(1, 11) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      bin_result_t e;
      n_recv++;
      if (expected_bins.size() == 0) begin
        $error("result beat with no prediction pending");
        errors++;
      end else begin
        e = expected_bins[0];
        expected_bins.delete(0);
        if (m_axis_tdata[15:0] !== e.re) begin
          $error("out_re expected %0d got %0d", $signed(e.re), $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== e.im) begin
          $error("out_im expected %0d got %0d", $signed(e.im), $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tdata[48:32] !== e.gain) begin
          $error("applied_gain expected %0d got %0d", e.gain, m_axis_tdata[48:32]);
          errors++;
        end
        if (m_axis_tuser !== e.full) begin
          $error("history_full expected %0b got %0b", e.full, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  function automatic bin_item_t make_bin(int b, int re, int im, bit v);
    bin_item_t it;
    it.bin = 9'(b);
    it.re = 16'(re);
    it.im = 16'(im);
    it.voice = v;
    return it;
  endfunction

  // Configuration writes go through the predictor copy at the same edge.
  task automatic write_reg(lrbs_pkg::cfg_idx_e idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      lrbs_pkg::CFG_DECAY_RATIO: decay_q = val[15:0];
      lrbs_pkg::CFG_SUB_FACTOR:  subtract_q = val[15:0];
      lrbs_pkg::CFG_FLOOR_GAIN:  floor_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until the block has drained everything sent so far.
  task automatic drain();
    while (pending_bins.size() > 0 || expected_bins.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // A burst of frames: a few bins repeated so histories fill, with a
  // random magnitude, now and then a large one, and voice mostly on.
  task automatic queue_frames(int nitems, bit loud);
    int nb, b0, amp;
    bin_item_t it;
    nb = $urandom_range(1, 6);
    b0 = $urandom_range(0, 511);
    for (int k = 0; k < nitems; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        it.bin = 9'($urandom);
        it.re = 16'($urandom);
        it.im = 16'($urandom);
        it.voice = $urandom_range(0, 1);
      end else begin
        amp = loud ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
        if ($urandom_range(0, 3) == 0) amp = $urandom_range(20000, 32767);
        it.bin = 9'((b0 + k % nb) % 512);
        it.re = 16'($urandom_range(0, 1) ? amp : -amp - $urandom_range(0, 1));
        it.im = 16'($urandom_range(0, amp));
        if ($urandom_range(0, 1)) it.im = -it.im;
        it.voice = ($urandom_range(0, 4) != 0);
      end
      queue_bin(it);
    end
  endtask

  initial begin
    errors = 0; n_sent = 0; n_recv = 0; n_full = 0; n_sub = 0;
    cycles = 0;
    idle_enable = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = lrbs_pkg::CFG_DECAY_RATIO;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    decay_q = 16'd13231;
    subtract_q = 16'd58982;
    floor_q = 17'd6554;
    for (int i = 0; i < lrbs_pkg::NUM_BINS; i++) begin
      hist_fill[i] = 0;
      next_slot[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset defaults: fill bin 511 with extreme values,
    // then hit it with voice on and off, loud and silent; then ramp bin 3.
    for (int k = 0; k < 8; k++)
      queue_bin(make_bin(511, (k % 2) ? -32768 : 32767,
                         (k % 2) ? -32768 : 32767, k % 2));
    queue_bin(make_bin(511, -32768, -32768, 1));  // most negative parts
    queue_bin(make_bin(511, 0, 0, 1));            // zero magnitude
    queue_bin(make_bin(511, 100, -100, 0));       // no voice, floor gain
    for (int k = 0; k < 8; k++)
      queue_bin(make_bin(3, k * 100, 0, 1));
    queue_bin(make_bin(3, 32767, 32767, 1));      // far above the model
    queue_bin(make_bin(3, 1, 0, 1));
    drain();

    // Floor gain above one saturates; extreme decay and subtraction.
    write_reg(lrbs_pkg::CFG_FLOOR_GAIN, 17'h1FFFF);
    write_reg(lrbs_pkg::CFG_DECAY_RATIO, 16'hFFFF);
    write_reg(lrbs_pkg::CFG_SUB_FACTOR, 16'hFFFF);
    queue_bin(make_bin(511, 500, 500, 0));
    queue_bin(make_bin(3, 32767, -32768, 1));
    queue_bin(make_bin(3, -32768, 32767, 0));
    queue_frames(120, 1'b1);
    drain();

    write_reg(lrbs_pkg::CFG_FLOOR_GAIN, 17'd65536);
    write_reg(lrbs_pkg::CFG_DECAY_RATIO, 16'd0);
    write_reg(lrbs_pkg::CFG_SUB_FACTOR, 16'd0);
    queue_frames(100, 1'b0);
    drain();

    write_reg(lrbs_pkg::CFG_FLOOR_GAIN, 17'd0);
    write_reg(lrbs_pkg::CFG_DECAY_RATIO, 16'd60000);
    write_reg(lrbs_pkg::CFG_SUB_FACTOR, 16'd58982);
    write_reg(lrbs_pkg::CFG_UNUSED, 17'h1ABCD);
    queue_frames(180, 1'b1);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(lrbs_pkg::CFG_DECAY_RATIO, 16'($urandom));
      write_reg(lrbs_pkg::CFG_SUB_FACTOR, 16'($urandom));
      write_reg(lrbs_pkg::CFG_FLOOR_GAIN, 17'($urandom_range(0, 131071)));
      queue_frames(80, p[0]);
      drain();
    end

    // Last part runs at full rate on both sides.
    idle_enable = 1'b0;
    queue_frames(100, 1'b1);
    drain();

    if (expected_bins.size() != 0) begin
      $error("%0d predictions never matched", expected_bins.size());
      errors++;
    end
    $display("Sent %0d bins, checked %0d results; %0d with full history, %0d suppressed.",
             n_sent, n_recv, n_full, n_sub);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
